// ===== rtl/core/led_segment_scan_keyboard_defines.svh =====
// Assertion macros shared by the display scanner RTL
`ifndef LED_SEGMENT_SCAN_KEYBOARD_DEFINES_SVH
`define LED_SEGMENT_SCAN_KEYBOARD_DEFINES_SVH

// Clocked check, disabled while reset is asserted
`define LSSK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lssk check failed");

// Clocked check that also holds during reset
`define LSSK_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("lssk check failed");

`endif

// ===== rtl/core/lssk_pkg.sv =====
// Shared types, constants and segment map for the display scanner
`default_nettype none
package lssk_pkg;

  localparam int DIGIT_COUNT   = 12;
  localparam int SEGMENT_COUNT = 8;
  localparam int DRIVE_W       = 12;
  localparam int ADC_W         = 12;
  localparam int NUM_COLS      = 5;
  localparam int SEG_W         = $clog2(SEGMENT_COUNT);

  localparam logic [4:0] BLANK_CODE = 5'd31;
  localparam logic [4:0] MINUS_CODE = 5'd30;
  localparam int         MASK_BLANK = 3;
  localparam int         MASK_MINUS = 0;
  localparam int         MASK_POINT = 1;

  localparam logic [SEG_W-1:0] POINT_SEGMENT = SEG_W'(SEGMENT_COUNT - 1);
  localparam logic [SEG_W-1:0] LAST_SEGMENT  = SEG_W'(SEGMENT_COUNT - 1);
  localparam logic [SEG_W-1:0] FIRST_SEGMENT = '0;

  localparam logic [7:0]       ADC_ERROR       = 8'hFF;
  localparam logic [4:0]       PM_PATTERN      = 5'h13;
  localparam logic [7:0]       PM_CODE         = 8'd100;
  localparam logic [ADC_W-1:0] THRESHOLD_RESET = 12'd3000;

  // bit s lit for segment s (E,F,B,G,C,A,D,P order)
  localparam logic [7:0] SEG_TABLE [32] = '{
    8'h77, 8'h14, 8'h6D, 8'h7C, 8'h1E, 8'h7A, 8'h7B, 8'h34,
    8'h7F, 8'h7E, 8'h3F, 8'h5B, 8'h63, 8'h5D, 8'h6B, 8'h2B,
    8'h73, 8'h1F, 8'h55, 8'h43, 8'h19, 8'h59, 8'h2F, 8'h09,
    8'h4B, 8'h57, 8'h5E, 8'h06, 8'h74, 8'h80, 8'h08, 8'h00
  };

  typedef logic [NUM_COLS-1:0][ADC_W-1:0] col_arr_t;

  // control for one key-sense step
  typedef struct packed {
    logic             fire;
    logic [SEG_W-1:0] seg;
    logic             failed;
  } key_step_t;

endpackage
`default_nettype wire

// ===== rtl/core/lssk_key_sense.sv =====
// Keypad row sensing: column thresholding, held scancode, end-of-cycle report
`include "led_segment_scan_keyboard_defines.svh"
`default_nettype none
module lssk_key_sense (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire lssk_pkg::key_step_t step_i,
  input  wire lssk_pkg::col_arr_t  cols_i,
  input  wire [lssk_pkg::ADC_W-1:0] threshold_i,
  output logic [7:0]              scancode_o
);
  import lssk_pkg::*;

  logic [7:0]          held_q, held_d, held_next, sample;
  logic [NUM_COLS-1:0] raw, frp_q, frp_d;
  logic [3:0]          row;
  logic [3:0]          col;
  logic                done;

  always_comb begin
    raw = '0;
    col = '0;
    for (int k = NUM_COLS - 1; k >= 0; k--) begin
      raw[k] = cols_i[k] > threshold_i;
      if (raw[k]) begin
        col = 4'(k + 1);
      end
    end
    row = 4'(step_i.seg) + 4'd1;
    if (step_i.failed) begin
      sample = ADC_ERROR;
    end else if (raw != '0) begin
      sample = {row, col};
    end else begin
      sample = '0;
    end
    held_next = (held_q == '0) ? sample : held_q;
    done      = step_i.seg == LAST_SEGMENT;

    frp_d = frp_q;
    if (step_i.seg == FIRST_SEGMENT && held_q == '0) begin
      frp_d = step_i.failed ? '0 : raw;
    end

    if (done) begin
      scancode_o = (frp_q == PM_PATTERN) ? PM_CODE : held_next;
      held_d     = '0;
    end else begin
      scancode_o = '0;
      held_d     = held_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      frp_q  <= '0;
    end else if (step_i.fire) begin
      held_q <= held_d;
      frp_q  <= frp_d;
    end
  end

  `LSSK_ASSERT(a_held_clear_after_done,
    step_i.fire && step_i.seg == LAST_SEGMENT |=> held_q == '0)
  `LSSK_ASSERT(a_code_zero_mid_cycle,
    step_i.seg != LAST_SEGMENT |-> scancode_o == '0)
  `LSSK_ASSERT(a_held_sticky,
    step_i.fire && step_i.seg != LAST_SEGMENT && held_q != '0 |=> held_q == $past(held_q))

endmodule
`default_nettype wire

// ===== rtl/core/led_segment_scan_keyboard.sv =====
// Top level: seven-segment scan with digit store and keypad sensing
//
//  channel  | dir | handshake                        | payload
//  s_axis   | in  | s_axis_tvalid / s_axis_tready    | tdata fields, tuser = mode
//  m_axis   | out | m_axis_tvalid / m_axis_tready    | tdata fields, tlast = cycle_done
//  cfg      | in  | cfg_valid_i / cfg_ready_o        | column_threshold
//
// From input transaction to result: input register, then result register.
// One item per cycle unless stalled; loads retire in the input stage and give no result.
// A scan step waits in the input stage only while the result register is full and stalled.
// Reset: all digits blank, masks clear, segment 0, threshold 3000.
`include "led_segment_scan_keyboard_defines.svh"
`default_nettype none
module led_segment_scan_keyboard (
  input  wire         clk_i,
  input  wire         rst_ni,
  // position[3:0], char_code[11:4], digit_mask[15:12], column_one[27:16],
  // column_two[39:28], column_three[51:40], column_four[63:52],
  // column_five[75:64], conversion_failed[76], zero[79:77]
  input  wire  [79:0] s_axis_tdata,
  input  wire         s_axis_tuser,   // mode[0]
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // digit_drive[11:0], segment_index[14:12], segment_lit[15], scancode[23:16]
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,   // cycle_done
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [11:0] cfg_data_i
);
  import lssk_pkg::*;

  // configuration
  logic [ADC_W-1:0] thr_q;

  // input stage
  logic             s1_valid_q;
  logic             s1_mode_q;
  logic [3:0]       s1_pos_q;
  logic [7:0]       s1_char_q;
  logic [3:0]       s1_mask_q;
  col_arr_t         s1_cols_q;
  logic             s1_failed_q;
  logic             s1_adv, s_fire, out_load;

  // state
  logic [4:0]       digit_q [DIGIT_COUNT];
  logic [3:0]       mask_q  [DIGIT_COUNT];
  logic [SEG_W-1:0] seg_q;

  // result register
  logic               out_valid_q, out_valid_d;
  logic [DRIVE_W-1:0] out_drive_q;
  logic [SEG_W-1:0]   out_seg_q;
  logic               out_lit_q;
  logic [7:0]         out_code_q;
  logic               out_done_q;

  logic [DRIVE_W-1:0] drive;
  logic [7:0]         scancode;
  key_step_t          key_step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  assign out_load      = s1_valid_q && s1_mode_q && (!out_valid_q || m_axis_tready);
  assign s1_adv        = s1_valid_q && (!s1_mode_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_mode_q    <= s_axis_tuser;
      s1_pos_q     <= s_axis_tdata[3:0];
      s1_char_q    <= s_axis_tdata[11:4];
      s1_mask_q    <= s_axis_tdata[15:12];
      s1_cols_q[0] <= s_axis_tdata[27:16];
      s1_cols_q[1] <= s_axis_tdata[39:28];
      s1_cols_q[2] <= s_axis_tdata[51:40];
      s1_cols_q[3] <= s_axis_tdata[63:52];
      s1_cols_q[4] <= s_axis_tdata[75:64];
      s1_failed_q  <= s_axis_tdata[76];
    end
  end

  // digit and mask store; out-of-range positions match no slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit_q[i] <= BLANK_CODE;
        mask_q[i]  <= '0;
      end
    end else if (s1_adv && !s1_mode_q) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        if (s1_pos_q == 4'(i)) begin
          digit_q[i] <= (s1_char_q[7:5] != '0) ? BLANK_CODE : s1_char_q[4:0];
          mask_q[i]  <= s1_mask_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= '0;
    end else if (s1_adv && s1_mode_q) begin
      seg_q <= seg_q + 1'b1;
    end
  end

  // digit drive word, position 0 at the top used bit
  always_comb begin
    logic [4:0] code;
    logic       bit_v;
    drive = '0;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (mask_q[i][MASK_BLANK]) begin
        code = BLANK_CODE;
      end else if (mask_q[i][MASK_MINUS]) begin
        code = MINUS_CODE;
      end else begin
        code = digit_q[i];
      end
      bit_v = (seg_q == POINT_SEGMENT) ? mask_q[i][MASK_POINT] : SEG_TABLE[code][seg_q];
      if (DIGIT_COUNT - 1 - i < DRIVE_W) begin
        drive[DIGIT_COUNT-1-i] = bit_v;
      end
    end
  end

  assign key_step.fire   = s1_adv && s1_mode_q;
  assign key_step.seg    = seg_q;
  assign key_step.failed = s1_failed_q;

  lssk_key_sense u_key_sense (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (key_step),
    .cols_i      (s1_cols_q),
    .threshold_i (thr_q),
    .scancode_o  (scancode)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_drive_q <= drive;
      out_seg_q   <= seg_q;
      out_lit_q   <= drive != '0;
      out_code_q  <= scancode;
      out_done_q  <= seg_q == LAST_SEGMENT;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_code_q, out_lit_q, out_seg_q, out_drive_q};
  assign m_axis_tlast  = out_done_q;

  `LSSK_ASSERT(a_last_on_point_segment,
    out_valid_q |-> (out_done_q == (out_seg_q == LAST_SEGMENT)))
  `LSSK_ASSERT(a_lit_matches_drive,
    out_valid_q |-> (out_lit_q == (out_drive_q != '0)))
  `LSSK_ASSERT(a_code_only_on_last,
    out_valid_q && !out_done_q |-> out_code_q == '0)
  `LSSK_ASSERT(a_seg_advances,
    s1_adv && s1_mode_q |=> seg_q == $past(seg_q) + 1'b1)
  `LSSK_ASSERT_ALWAYS(a_no_load_into_result,
    out_load |-> s1_mode_q)

endmodule
`default_nettype wire

// ===== sim/led_scan_checker.sv =====
// Scan-step predictor and result checker for the display scanner, with shared bench types
`timescale 1ns / 100ps
package scan_tb_pkg;

  typedef enum logic {MODE_LOAD = 1'b0, MODE_SCAN = 1'b1} scan_mode_e;

  // s_axis tdata layout, first member at the top
  typedef struct packed {
    logic [2:0]  zero;
    logic        conv_failed;
    logic [11:0] col5;
    logic [11:0] col4;
    logic [11:0] col3;
    logic [11:0] col2;
    logic [11:0] col1;
    logic [3:0]  mask;
    logic [7:0]  char_code;
    logic [3:0]  position;
  } scan_item_t;

  // m_axis tdata layout
  typedef struct packed {
    logic [7:0]  scancode;
    logic        lit;
    logic [2:0]  seg;
    logic [11:0] drive;
  } result_fields_t;

  typedef struct packed {
    logic           done;
    result_fields_t fields;
  } scan_result_t;

endpackage

module led_scan_checker (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire [79:0] s_tdata,
  input  wire        s_tuser,
  input  wire        s_tvalid,
  input  wire        s_tready,
  input  wire [23:0] m_tdata,
  input  wire        m_tlast,
  input  wire        m_tvalid,
  input  wire        m_tready,
  input  wire        cfg_valid,
  input  wire        cfg_ready,
  input  wire [11:0] cfg_data,
  output int         mismatches,
  output int         pending
);
  import lssk_pkg::*;
  import scan_tb_pkg::*;

  logic [4:0]       digit_q [DIGIT_COUNT];
  logic [3:0]       mask_q  [DIGIT_COUNT];
  logic [SEG_W-1:0] seg_q;
  logic [7:0]       held_q;
  logic [4:0]       row0_q;
  logic [ADC_W-1:0] thr_q;
  scan_result_t     expected_q [$];
  int               fail_n = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic logic [DRIVE_W-1:0] drive_for(logic [SEG_W-1:0] seg);
    logic [DRIVE_W-1:0] d;
    logic [4:0]         c;
    d = '0;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (seg == POINT_SEGMENT) begin
        // point ignores the blank bit
        d[DIGIT_COUNT-1-i] = mask_q[i][MASK_POINT];
      end else begin
        c = digit_q[i];
        if (mask_q[i][MASK_BLANK]) begin
          c = BLANK_CODE;
        end else if (mask_q[i][MASK_MINUS]) begin
          c = MINUS_CODE;
        end
        d[DIGIT_COUNT-1-i] = SEG_TABLE[c][seg];
      end
    end
    return d;
  endfunction

  function automatic scan_result_t next_scan_result(scan_item_t it);
    scan_result_t     r;
    logic [11:0]      cols [NUM_COLS];
    logic [4:0]       raw;
    logic [3:0]       col;
    logic [3:0]       row;
    logic [SEG_W-1:0] seg;
    seg = seg_q;
    cols = '{it.col1, it.col2, it.col3, it.col4, it.col5};
    r.fields.drive    = drive_for(seg);
    r.fields.seg      = seg;
    r.fields.lit      = |r.fields.drive;
    r.fields.scancode = '0;
    if (held_q == '0) begin
      if (it.conv_failed) begin
        if (seg == FIRST_SEGMENT) row0_q = '0;
        held_q = ADC_ERROR;
      end else begin
        raw = '0;
        col = '0;
        row = '0;
        // walk down so the lowest closed column is the one kept
        for (int k = NUM_COLS; k > 0; k--) begin
          raw = raw << 1;
          if (cols[k-1] > thr_q) begin
            raw[0] = 1'b1;
            col    = 4'(k);
            row    = 4'(seg) + 4'd1;
          end
        end
        if (seg == FIRST_SEGMENT) row0_q = raw;
        held_q = {row, col};
      end
    end
    r.done = (seg == LAST_SEGMENT);
    if (r.done) begin
      r.fields.scancode = (row0_q == PM_PATTERN) ? PM_CODE : held_q;
      held_q = '0;
    end
    seg_q = seg + 1'b1;
    return r;
  endfunction

  always @(posedge clk_i) begin
    scan_item_t   it;
    scan_result_t got;
    scan_result_t want;
    if (!rst_ni) begin
      foreach (digit_q[i]) begin
        digit_q[i] = BLANK_CODE;
        mask_q[i]  = '0;
      end
      seg_q  = FIRST_SEGMENT;
      held_q = '0;
      row0_q = '0;
      thr_q  = THRESHOLD_RESET;
      expected_q.delete();
      fail_n = 0;
    end else begin
      if (cfg_valid && cfg_ready) thr_q = cfg_data;
      // results already in flight come from earlier transactions, so check first
      if (m_tvalid && m_tready) begin
        got.fields = m_tdata;
        got.done   = m_tlast;
        if (expected_q.size() == 0) begin
          if (fail_n < 10)
            $display("%0t: unexpected result drive=%03h seg=%0d lit=%b code=%0d last=%b",
                     $time, got.fields.drive, got.fields.seg, got.fields.lit,
                     got.fields.scancode, got.done);
          fail_n++;
        end else begin
          want = expected_q.pop_front();
          if (got.fields.drive !== want.fields.drive || got.fields.seg !== want.fields.seg ||
              got.fields.lit !== want.fields.lit ||
              got.fields.scancode !== want.fields.scancode || got.done !== want.done) begin
            if (fail_n < 10)
              $display({"%0t: result mismatch, expected drive=%03h seg=%0d lit=%b code=%0d ",
                        "last=%b, got drive=%03h seg=%0d lit=%b code=%0d last=%b"},
                       $time, want.fields.drive, want.fields.seg, want.fields.lit,
                       want.fields.scancode, want.done, got.fields.drive, got.fields.seg,
                       got.fields.lit, got.fields.scancode, got.done);
            fail_n++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        it = s_tdata;
        if (scan_mode_e'(s_tuser) == MODE_SCAN) begin
          expected_q.push_back(next_scan_result(it));
        end else if (it.position < DIGIT_COUNT) begin
          digit_q[it.position] = (it.char_code > BLANK_CODE) ? BLANK_CODE : it.char_code[4:0];
          mask_q[it.position]  = it.mask;
        end
      end
    end
    pending    <= expected_q.size();
    mismatches <= fail_n;
  end

endmodule

// ===== sim/testbench.sv =====
// Bench top for the display scanner: clock, reset, stimulus, stall patterns and verdict
`timescale 1ns / 100ps
module testbench;
  import lssk_pkg::*;
  import scan_tb_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int LONG_HOLD     = 150;
  localparam int SETTLE_CYCLES = 6;

  localparam logic [3:0] M_BLANK = 4'(1 << MASK_BLANK);
  localparam logic [3:0] M_MINUS = 4'(1 << MASK_MINUS);
  localparam logic [3:0] M_POINT = 4'(1 << MASK_POINT);

  typedef enum int {RX_OPEN, RX_COIN, RX_RARE_STALL, RX_SLOW} rx_style_e;

  logic        clk_i;
  logic        rst_ni;
  logic [79:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tvalid;
  wire         s_axis_tready;
  wire  [23:0] m_axis_tdata;
  wire         m_axis_tlast;
  wire         m_axis_tvalid;
  logic        m_axis_tready;
  logic        cfg_valid_i;
  wire         cfg_ready_o;
  logic [11:0] cfg_data_i;
  int          mismatches;
  int          pending;

  int               hold_requests = 0;
  int               idle_cycles   = 0;
  logic [ADC_W-1:0] thr_shadow    = THRESHOLD_RESET;
  logic [SEG_W-1:0] seg_next      = FIRST_SEGMENT;  // segment the next scan step hits
  int               key_row       = 0;              // row pressed this cycle, none if >= 8
  logic             pm_cycle      = 1'b0;

  led_segment_scan_keyboard dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  led_scan_checker u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata    (s_axis_tdata),
    .s_tuser    (s_axis_tuser),
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .m_tdata    (m_axis_tdata),
    .m_tlast    (m_axis_tlast),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .cfg_valid  (cfg_valid_i),
    .cfg_ready  (cfg_ready_o),
    .cfg_data   (cfg_data_i),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog: cycles in a row without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: changing stall styles, plus long hold-offs on request
  initial begin
    rx_style_e style;
    int        left;
    int        served;
    m_axis_tready = 1'b0;
    style  = RX_OPEN;
    left   = 0;
    served = 0;
    forever begin
      if (served != hold_requests) begin
        served++;
        repeat (LONG_HOLD) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b0;
        end
      end else begin
        if (left == 0) begin
          style = rx_style_e'($urandom_range(3, 0));
          left  = $urandom_range(80, 16);
        end
        left--;
        @(negedge clk_i);
        case (style)
          RX_OPEN:       m_axis_tready <= 1'b1;
          RX_COIN:       m_axis_tready <= 1'($urandom_range(1, 0));
          RX_RARE_STALL: m_axis_tready <= ($urandom_range(7, 0) != 0);
          default:       m_axis_tready <= ($urandom_range(3, 0) == 0);
        endcase
      end
    end
  end

  task automatic send_item(scan_mode_e mode, scan_item_t it);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= it;
    do @(posedge clk_i); while (!s_axis_tready);
    if (mode == MODE_SCAN) seg_next = seg_next + 1'b1;
  endtask

  task automatic sender_gap(int cycles);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // loads give no result, so keep waiting after the last expected result to let them settle
  task automatic wait_drained();
    sender_gap(1);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [ADC_W-1:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    thr_shadow = value;
  endtask

  function automatic scan_item_t make_item(logic [3:0] pos, logic [7:0] code,
                                           logic [3:0] mask, logic [11:0] c1,
                                           logic [11:0] c2, logic [11:0] c3,
                                           logic [11:0] c4, logic [11:0] c5,
                                           logic failed);
    scan_item_t it;
    it = '0;
    it.position    = pos;
    it.char_code   = code;
    it.mask        = mask;
    it.col1        = c1;
    it.col2        = c2;
    it.col3        = c3;
    it.col4        = c4;
    it.col5        = c5;
    it.conv_failed = failed;
    return it;
  endfunction

  function automatic logic [ADC_W-1:0] closed_level();
    if (thr_shadow == '1) return '1;
    return ADC_W'($urandom_range(4095, thr_shadow + 1));
  endfunction

  function automatic logic [ADC_W-1:0] open_level();
    if ($urandom_range(9, 0) == 0) return thr_shadow;
    return ADC_W'($urandom_range(thr_shadow, 0));
  endfunction

  function automatic scan_item_t random_scan_item();
    scan_item_t       it;
    logic [79:0]      bits;
    logic [ADC_W-1:0] lv [NUM_COLS];
    bits = 80'({$urandom, $urandom, $urandom});
    it = bits;
    it.zero = '0;
    // one pressed row per scan cycle keeps the held code interesting
    if (seg_next == FIRST_SEGMENT) begin
      key_row  = $urandom_range(11, 0);
      pm_cycle = ($urandom_range(5, 0) == 0);
    end
    for (int k = 0; k < NUM_COLS; k++) begin
      if ($urandom_range(9, 0) == 0) begin
        lv[k] = ADC_W'($urandom);
      end else if (seg_next == FIRST_SEGMENT && pm_cycle) begin
        lv[k] = PM_PATTERN[k] ? closed_level() : open_level();
      end else if (int'(seg_next) == key_row && $urandom_range(1, 0)) begin
        lv[k] = closed_level();
      end else begin
        lv[k] = open_level();
      end
    end
    it.col1 = lv[0];
    it.col2 = lv[1];
    it.col3 = lv[2];
    it.col4 = lv[3];
    it.col5 = lv[4];
    it.conv_failed = ($urandom_range(19, 0) == 0);
    return it;
  endfunction

  function automatic scan_item_t random_load_item();
    scan_item_t  it;
    logic [79:0] bits;
    bits = 80'({$urandom, $urandom, $urandom});
    it = bits;
    it.zero = '0;
    it.position = ($urandom_range(7, 0) == 0) ? 4'($urandom_range(15, 12))
                                              : 4'($urandom_range(11, 0));
    it.char_code = $urandom_range(1, 0) ? 8'($urandom_range(31, 0)) : 8'($urandom);
    it.mask = $urandom_range(1, 0) ? 4'($urandom) : 4'h0;
    return it;
  endfunction

  task automatic run_random(int count, int hold_at, int drain_at);
    int burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_requests++;
      if (n == drain_at) wait_drained();
      if (burst == 0) begin
        burst = ($urandom_range(3, 0) == 0) ? $urandom_range(120, 40) : $urandom_range(12, 1);
        sender_gap($urandom_range(10, 1));
      end
      burst--;
      if ($urandom_range(3, 0) == 0) send_item(MODE_LOAD, random_load_item());
      else send_item(MODE_SCAN, random_scan_item());
    end
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // scan of the reset display, nothing closed (3000 sits on the threshold)
    send_item(MODE_SCAN, make_item(4'd0, 8'd0, 4'h0, 12'd0, 12'd3000, 12'd0, 12'd0, 12'd0,
                                   1'b0));
    send_item(MODE_LOAD, make_item(4'd0, 8'd8, 4'h0, '0, '0, '0, '0, '0, 1'b0));
    send_item(MODE_LOAD, make_item(4'd11, 8'd255, 4'h0, '0, '0, '0, '0, '0, 1'b0));
    send_item(MODE_LOAD, make_item(4'd15, 8'd5, 4'hF, '0, '0, '0, '0, '0, 1'b0));
    send_item(MODE_LOAD, make_item(4'd5, 8'd3, M_BLANK, '0, '0, '0, '0, '0, 1'b0));
    send_item(MODE_LOAD, make_item(4'd6, 8'd4, M_MINUS, '0, '0, '0, '0, '0, 1'b0));
    send_item(MODE_LOAD, make_item(4'd7, 8'd0, M_POINT, '0, '0, '0, '0, '0, 1'b0));
    send_item(MODE_LOAD, make_item(4'd8, 8'd8, M_BLANK | M_MINUS | M_POINT,
                                   '0, '0, '0, '0, '0, 1'b0));
    send_item(MODE_LOAD, make_item(4'd1, 8'd32, 4'h0, '0, '0, '0, '0, '0, 1'b0));
    send_item(MODE_LOAD, make_item(4'd3, 8'd30, 4'h0, '0, '0, '0, '0, '0, 1'b0));
    send_item(MODE_LOAD, make_item(4'd4, 8'd31, M_BLANK | M_POINT, '0, '0, '0, '0, '0, 1'b0));
    send_item(MODE_LOAD, make_item(4'd10, 8'd29, M_MINUS | M_POINT, '0, '0, '0, '0, '0, 1'b0));
    // rest of the first cycle: ADC timeout on segment 2, later keys ignored
    for (int s = 1; s < SEGMENT_COUNT; s++)
      send_item(MODE_SCAN, make_item(4'd0, 8'd0, 4'h0, (s == 5) ? 12'd4095 : 12'd0,
                                     '0, '0, '0, '0, s == 2));
    // program manager pattern on row 0, with a competing key on row 3
    send_item(MODE_SCAN, make_item(4'd0, 8'd0, 4'h0, 12'd4095, 12'd3001, 12'd0, 12'd3000,
                                   12'd4095, 1'b0));
    for (int s = 1; s < SEGMENT_COUNT; s++)
      send_item(MODE_SCAN, make_item(4'd0, 8'd0, 4'h0, '0, '0, (s == 3) ? 12'd4095 : 12'd0,
                                     '0, '0, 1'b0));

    write_threshold(12'd0);
    run_random(300, -1, -1);
    write_threshold(12'd4095);
    run_random(200, -1, -1);
    write_threshold(12'($urandom_range(4000, 500)));
    run_random(300, 100, -1);
    write_threshold(12'd1);
    run_random(200, -1, 80);
    write_threshold(12'd4094);
    run_random(200, -1, -1);
    write_threshold(12'($urandom));
    run_random(300, 150, 220);
    write_threshold(THRESHOLD_RESET);
    run_random(300, -1, -1);

    wait_drained();
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== led_segment_scan_keyboard.f =====
+incdir+rtl/core
rtl/core/lssk_pkg.sv
rtl/core/lssk_key_sense.sv
rtl/core/led_segment_scan_keyboard.sv
sim/led_scan_checker.sv
sim/testbench.sv
